@@ hdl/sctp_pkg.sv @@
package sctp_pkg;

  localparam int LINE_LIMIT = 8192;
  localparam int LINE_W = $clog2(LINE_LIMIT);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int MAX_RESULTS = 3;

  localparam logic [1:0] CFG_MAX_SEGMENTS = 2'd0;
  localparam logic [1:0] CFG_MAX_SEG_BITS = 2'd1;
  localparam logic [1:0] CFG_MAX_TOTAL_BITS = 2'd2;

  typedef enum logic [3:0] {
    KS_START, KS_MATCH, KS_FREQ, KS_TE, KS_BIT, KS_BITRAW, KS_HEX, KS_HEXSTOP, KS_IGNORE
  } key_state_t;

  typedef enum logic [1:0] {NP_WS, NP_SIGNED, NP_DIGITS, NP_DONE} num_phase_t;

  typedef enum logic [2:0] {
    RK_FREQ, RK_TE, RK_BIT, RK_DATA, RK_PAD, RK_SEG_END, RK_DONE
  } res_kind_t;

  typedef enum logic [1:0] {ST_OK, ST_TRUNC, ST_MISSING, ST_NODATA} status_t;

  typedef struct packed {
    logic [7:0]  max_segments;
    logic [15:0] max_bits_per_segment;
    logic [19:0] max_total_bits;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] value;
    logic [7:0]  data_bits;
    logic [3:0]  bit_count;
    logic [7:0]  segment_index;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // Key texts, indexed by key number and character position.
  function automatic logic [7:0] key_char(input logic [2:0] k, input logic [3:0] pos);
    logic [79:0] s;
    case (k)
      3'd0: s = "Frequency:";
      3'd1: s = {"TE:", 56'd0};
      3'd2: s = {"Bit:", 48'd0};
      3'd3: s = {"Bit_RAW:", 16'd0};
      3'd4: s = {"Data_RAW:", 8'd0};
      default: s = '0;
    endcase
    key_char = s[8'd79 - {pos, 3'd0} -: 8];
  endfunction

  function automatic logic [3:0] key_len(input logic [2:0] k);
    case (k)
      3'd0: key_len = 4'd10;
      3'd1: key_len = 4'd3;
      3'd2: key_len = 4'd4;
      3'd3: key_len = 4'd8;
      3'd4: key_len = 4'd9;
      default: key_len = 4'd0;
    endcase
  endfunction

  function automatic key_state_t key_target(input logic [2:0] k);
    case (k)
      3'd0: key_target = KS_FREQ;
      3'd1: key_target = KS_TE;
      3'd2: key_target = KS_BIT;
      3'd3: key_target = KS_BITRAW;
      default: key_target = KS_HEX;
    endcase
  endfunction

  function automatic result_t mk_res(input res_kind_t kd, input logic [31:0] v,
                                     input logic [7:0] d, input logic [3:0] cnt,
                                     input logic [7:0] seg, input status_t st);
    result_t r;
    r.result_kind = kd;
    r.value = v;
    r.data_bits = d;
    r.bit_count = cnt;
    r.segment_index = seg;
    r.status = st;
    r.last = 1'b0;
    mk_res = r;
  endfunction

endpackage

@@ hdl/sctp_step.sv @@
module sctp_step (
  input  logic                  clk,
  input  logic                  rst,
  input  sctp_pkg::cfg_t        cfg,
  input  logic                  take,
  input  logic                  kind,
  input  logic [7:0]            character,
  output logic [1:0]            res_n,
  output sctp_pkg::result_t     res [sctp_pkg::MAX_RESULTS]
);
  import sctp_pkg::*;

  logic [LINE_W-1:0] line_length, line_length_next;
  logic line_overflow, line_overflow_next;
  key_state_t kstate, kstate_next;
  logic [4:0] cands, cands_next;
  logic [3:0] kpos, kpos_next;
  num_phase_t nphase, nphase_next;
  logic nsat, nsat_next;
  logic [31:0] acc, acc_next;
  logic neg, neg_next;
  logic [4:0] high_nibble, high_nibble_next;
  logic [15:0] bits_emitted, bits_emitted_next;
  logic [15:0] bit_limit, bit_limit_next;
  logic lfh, lfh_next;
  logic [31:0] pending_count, pending_count_next;
  logic pending_valid, pending_valid_next;
  logic seen_freq, seen_freq_next;
  logic seen_te, seen_te_next;
  logic [7:0] seg_count, seg_count_next;
  logic [19:0] bits_used, bits_used_next;
  logic trunc, trunc_next;

  always_comb begin
    logic [1:0] n;
    logic do_fin, do_match, done_key;
    logic [4:0] keep;
    logic [35:0] prod;
    logic [3:0] dig;
    logic [4:0] hv;
    logic [7:0] byte_v;
    logic [15:0] k16, len, lim;
    logic [19:0] remaining;
    logic [31:0] declared, v;
    status_t st;
    line_length_next = line_length;
    line_overflow_next = line_overflow;
    kstate_next = kstate;
    cands_next = cands;
    kpos_next = kpos;
    nphase_next = nphase;
    nsat_next = nsat;
    acc_next = acc;
    neg_next = neg;
    high_nibble_next = high_nibble;
    bits_emitted_next = bits_emitted;
    bit_limit_next = bit_limit;
    lfh_next = lfh;
    pending_count_next = pending_count;
    pending_valid_next = pending_valid;
    seen_freq_next = seen_freq;
    seen_te_next = seen_te;
    seg_count_next = seg_count;
    bits_used_next = bits_used;
    trunc_next = trunc;
    n = 2'd0;
    do_fin = 1'b0;
    do_match = 1'b0;
    done_key = 1'b0;
    keep = '0;
    prod = '0;
    dig = '0;
    hv = '0;
    byte_v = '0;
    k16 = '0;
    len = '0;
    lim = '0;
    remaining = '0;
    declared = '0;
    v = '0;
    st = ST_OK;
    for (int i = 0; i < MAX_RESULTS; i++) res[i] = '0;

    if (take) begin
      if (kind) begin
        do_fin = 1'b1;
      end else if (character == 8'h0A || character == 8'h0D) begin
        do_fin = 1'b1;
      end else if (!line_overflow &&
                   ({1'b0, line_length} + 1'b1) < (LINE_W+1)'(LINE_LIMIT)) begin
        line_length_next = line_length + 1'b1;
        case (kstate)
          KS_START: begin
            if (character != 8'h20 && character != 8'h09) begin
              kstate_next = KS_MATCH;
              cands_next = 5'h1F;
              kpos_next = 4'd0;
              do_match = 1'b1;
            end
          end
          KS_MATCH: do_match = 1'b1;
          KS_FREQ, KS_TE, KS_BIT, KS_BITRAW: begin
            if (character == 8'h00) begin
              nphase_next = NP_DONE;
            end else if (character >= "0" && character <= "9" && nphase != NP_DONE) begin
              dig = 4'(character - "0");
              nphase_next = NP_DIGITS;
              if (!nsat) begin
                prod = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + {32'b0, dig};
                if (prod[35:32] != 4'd0) begin
                  acc_next = 32'hFFFF_FFFF;
                  nsat_next = 1'b1;
                end else begin
                  acc_next = prod[31:0];
                end
              end
            end else if (nphase == NP_WS && (character == 8'h20 || character == 8'h09 ||
                         character == 8'h0B || character == 8'h0C)) begin
              nphase_next = NP_WS;
            end else if (nphase == NP_WS && (character == "+" || character == "-")) begin
              neg_next = (character == "-");
              nphase_next = NP_SIGNED;
            end else begin
              nphase_next = NP_DONE;
            end
          end
          KS_HEX: begin
            if (character >= "0" && character <= "9") hv = {1'b1, 4'(character - "0")};
            else if (character >= "a" && character <= "f") hv = {1'b1, 4'(character - "a" + 8'd10)};
            else if (character >= "A" && character <= "F") hv = {1'b1, 4'(character - "A" + 8'd10)};
            if (character == 8'h00) begin
              kstate_next = KS_HEXSTOP;
            end else if (hv[4]) begin
              if (!high_nibble[4]) begin
                high_nibble_next = hv;
              end else begin
                byte_v = {high_nibble[3:0], hv[3:0]};
                high_nibble_next = '0;
                if (bits_emitted >= bit_limit) begin
                  if (!lfh) trunc_next = 1'b1;
                end else begin
                  k16 = bit_limit - bits_emitted;
                  if (k16 > 16'd8) k16 = 16'd8;
                  if (k16 < 16'd8 && !lfh) trunc_next = 1'b1;
                  byte_v = byte_v & (8'hFF << (4'd8 - k16[3:0]));
                  res[n] = mk_res(RK_DATA, 32'd0, byte_v, k16[3:0], seg_count, ST_OK);
                  n = n + 1'b1;
                  bits_emitted_next = bits_emitted + k16;
                end
              end
            end
          end
          default: ;
        endcase

        // Advance the key matcher over all live candidates.
        if (do_match) begin
          for (int k = 0; k < 5; k++) begin
            if (cands_next[k] && kpos_next < key_len(3'(k)) &&
                key_char(3'(k), kpos_next) == character)
              keep[k] = 1'b1;
          end
          cands_next = keep;
          if (keep == 5'd0) begin
            kstate_next = KS_IGNORE;
          end else begin
            for (int k = 0; k < 5; k++) begin
              if (!done_key && keep[k] && key_len(3'(k)) == kpos_next + 1'b1) begin
                done_key = 1'b1;
                nphase_next = NP_WS;
                acc_next = '0;
                neg_next = 1'b0;
                nsat_next = 1'b0;
                if (key_target(3'(k)) == KS_HEX) begin
                  declared = pending_valid ? pending_count : 32'd0;
                  pending_valid_next = 1'b0;
                  pending_count_next = '0;
                  if (seg_count >= cfg.max_segments || bits_used >= cfg.max_total_bits) begin
                    trunc_next = 1'b1;
                    kstate_next = KS_IGNORE;
                  end else begin
                    remaining = cfg.max_total_bits - bits_used;
                    lim = cfg.max_bits_per_segment;
                    if (remaining < {4'd0, lim}) lim = remaining[15:0];
                    bits_emitted_next = '0;
                    high_nibble_next = '0;
                    if (declared != 32'd0) begin
                      lfh_next = 1'b1;
                      if (declared > {16'd0, lim}) begin
                        trunc_next = 1'b1;
                        declared = {16'd0, lim};
                      end
                      bit_limit_next = declared[15:0];
                      kstate_next = (declared[15:0] == 16'd0) ? KS_IGNORE : KS_HEX;
                    end else begin
                      lfh_next = 1'b0;
                      bit_limit_next = lim;
                      kstate_next = KS_HEX;
                    end
                  end
                end else begin
                  kstate_next = key_target(3'(k));
                end
              end
            end
            if (!done_key) kpos_next = kpos_next + 1'b1;
          end
        end
      end else begin
        line_overflow_next = 1'b1;
      end

      // Close the line: report or keep numbers, pad and segment end.
      if (do_fin) begin
        if (line_overflow) trunc_next = 1'b1;
        if (kstate == KS_FREQ || kstate == KS_TE || kstate == KS_BIT || kstate == KS_BITRAW) begin
          v = (!nsat && neg) ? (32'd0 - acc) : acc;
          case (kstate)
            KS_FREQ: begin
              res[n] = mk_res(RK_FREQ, v, 8'd0, 4'd0, 8'd0, ST_OK);
              n = n + 1'b1;
              seen_freq_next = 1'b1;
            end
            KS_TE: begin
              res[n] = mk_res(RK_TE, v, 8'd0, 4'd0, 8'd0, ST_OK);
              n = n + 1'b1;
              seen_te_next = 1'b1;
            end
            KS_BIT: begin
              res[n] = mk_res(RK_BIT, v, 8'd0, 4'd0, 8'd0, ST_OK);
              n = n + 1'b1;
            end
            default: begin
              pending_count_next = v;
              pending_valid_next = 1'b1;
            end
          endcase
        end else if (kstate == KS_HEX || kstate == KS_HEXSTOP) begin
          len = bits_emitted;
          if (lfh) begin
            if (bits_emitted < bit_limit) begin
              res[n] = mk_res(RK_PAD, {16'd0, bit_limit - bits_emitted}, 8'd0, 4'd0,
                              seg_count, ST_OK);
              n = n + 1'b1;
              trunc_next = 1'b1;
            end
            len = bit_limit;
          end
          if (len != 16'd0) begin
            res[n] = mk_res(RK_SEG_END, {16'd0, len}, 8'd0, 4'd0, seg_count, ST_OK);
            n = n + 1'b1;
            seg_count_next = seg_count + 1'b1;
            bits_used_next = bits_used + {4'd0, len};
          end
        end
        line_length_next = '0;
        line_overflow_next = 1'b0;
        kstate_next = KS_START;
        cands_next = '0;
        kpos_next = '0;
        nphase_next = NP_WS;
        nsat_next = 1'b0;
        acc_next = '0;
        neg_next = 1'b0;
        high_nibble_next = '0;
        bits_emitted_next = '0;
        bit_limit_next = '0;
        lfh_next = 1'b0;
      end

      // End of file: report status and drop back to the reset state.
      if (kind) begin
        if (!seen_freq_next || !seen_te_next) st = ST_MISSING;
        else if (seg_count_next == 8'd0) st = ST_NODATA;
        else if (trunc_next) st = ST_TRUNC;
        else st = ST_OK;
        res[n] = mk_res(RK_DONE, 32'd0, 8'd0, 4'd0, 8'd0, st);
        n = n + 1'b1;
        pending_count_next = '0;
        pending_valid_next = 1'b0;
        seen_freq_next = 1'b0;
        seen_te_next = 1'b0;
        seg_count_next = '0;
        bits_used_next = '0;
        trunc_next = 1'b0;
      end
    end
    res_n = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      line_overflow <= 1'b0;
      kstate <= KS_START;
      cands <= '0;
      kpos <= '0;
      nphase <= NP_WS;
      nsat <= 1'b0;
      acc <= '0;
      neg <= 1'b0;
      high_nibble <= '0;
      bits_emitted <= '0;
      bit_limit <= '0;
      lfh <= 1'b0;
      pending_count <= '0;
      pending_valid <= 1'b0;
      seen_freq <= 1'b0;
      seen_te <= 1'b0;
      seg_count <= '0;
      bits_used <= '0;
      trunc <= 1'b0;
    end else begin
      line_length <= line_length_next;
      line_overflow <= line_overflow_next;
      kstate <= kstate_next;
      cands <= cands_next;
      kpos <= kpos_next;
      nphase <= nphase_next;
      nsat <= nsat_next;
      acc <= acc_next;
      neg <= neg_next;
      high_nibble <= high_nibble_next;
      bits_emitted <= bits_emitted_next;
      bit_limit <= bit_limit_next;
      lfh <= lfh_next;
      pending_count <= pending_count_next;
      pending_valid <= pending_valid_next;
      seen_freq <= seen_freq_next;
      seen_te <= seen_te_next;
      seg_count <= seg_count_next;
      bits_used <= bits_used_next;
      trunc <= trunc_next;
    end
  end

endmodule

@@ hdl/sctp_rqueue.sv @@
module sctp_rqueue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  sctp_pkg::result_t push [sctp_pkg::MAX_RESULTS],
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output sctp_pkg::result_t head
);
  import sctp_pkg::*;

  result_t mem [QUEUE_DEPTH];
  result_t entry_in [MAX_RESULTS];
  logic [QPTR_W-1:0] wptr, wptr_next, rptr, rptr_next;
  logic [QPTR_W:0] count, count_next;
  logic pop;

  assign out_valid = (count != '0);
  assign pop = out_valid && !out_stall;
  assign head = mem[rptr];
  // Hold off input unless a worst-case item still fits.
  assign room = (count <= (QPTR_W+1)'(QUEUE_DEPTH - MAX_RESULTS));

  always_comb begin
    wptr_next = wptr + QPTR_W'(push_n);
    rptr_next = rptr + QPTR_W'(pop);
    count_next = count + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(pop);
  end

  // Mark the final result of the transaction before it is stored.
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      entry_in[i] = push[i];
      entry_in[i].last = (i == int'(push_n) - 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (i < int'(push_n)) begin
        mem[wptr + QPTR_W'(i)] <= entry_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr_next;
      rptr <= rptr_next;
      count <= count_next;
    end
  end

endmodule

@@ hdl/sub_capture_text_parser.sv @@
// Capture text parser.
// Input channel (in_valid/in_stall, kind, character): one text byte per
// transaction, or an end-of-file marker when kind is set. Output channel
// (out_valid/out_stall plus the result fields): decoded numbers, data bytes
// MSB first, zero pads, segment ends and a final done with the status.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
// segment count, per-segment bit and total bit limits; cfg_ready is always
// high and writes should happen only while the parser is idle.
// Results are formed combinationally and written into the result queue.
// Throughput: one byte per cycle while in_stall is low; the per-byte state
// update is a single registered pass. A byte that closes a line or the file
// can yield up to three results, which drain from a four-entry queue at one
// per cycle while out_stall is low; input stalls unless three more fit.
// Reset restores the limit defaults and clears the parser to start of file.
// When the receiver stalls, the queue holds its head result steady and
// in_stall rises once the queue runs short of room.
module sub_capture_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  character,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [31:0] value,
  output logic [7:0]  data_bits,
  output logic [3:0]  bit_count,
  output logic [7:0]  segment_index,
  output logic [1:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import sctp_pkg::*;

  cfg_t cfg;
  logic take, room;
  logic [1:0] res_n;
  result_t res [MAX_RESULTS];
  result_t head;

  assign cfg_ready = 1'b1;

  // Limit registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_segments <= 8'd16;
      cfg.max_bits_per_segment <= 16'd16384;
      cfg.max_total_bits <= 20'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_SEGMENTS:   cfg.max_segments <= cfg_data[7:0];
        CFG_MAX_SEG_BITS:   cfg.max_bits_per_segment <= cfg_data[15:0];
        CFG_MAX_TOTAL_BITS: cfg.max_total_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !room;
  assign take = in_valid && !in_stall;

  sctp_step u_step (
    .clk(clk), .rst(rst), .cfg(cfg), .take(take), .kind(kind),
    .character(character), .res_n(res_n), .res(res)
  );

  sctp_rqueue u_queue (
    .clk(clk), .rst(rst), .push_n(res_n), .push(res), .room(room),
    .out_valid(out_valid), .out_stall(out_stall), .head(head)
  );

  assign result_kind = head.result_kind;
  assign value = head.value;
  assign data_bits = head.data_bits;
  assign bit_count = head.bit_count;
  assign segment_index = head.segment_index;
  assign status = head.status;
  assign last = head.last;

endmodule

@@ tb/tb_sub_capture_text_parser.sv @@
module tb_sub_capture_text_parser;
  import sctp_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [7:0]  character;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  result_kind;
  logic [31:0] value;
  logic [7:0]  data_bits;
  logic [3:0]  bit_count;
  logic [7:0]  segment_index;
  logic [1:0]  status;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  sub_capture_text_parser dut (.*);

  // Parser state copy used to predict the result stream.
  logic [7:0]  lim_segs;
  logic [15:0] lim_seg_bits;
  logic [19:0] lim_total;

  int unsigned p_len;
  bit          p_ovf;
  key_state_t  p_ks;
  logic [4:0]  p_cands;
  int unsigned p_kpos;
  num_phase_t  p_np;
  bit          p_sat;
  logic [31:0] p_acc;
  bit          p_neg;
  logic [4:0]  p_hi;
  int unsigned p_emitted;
  int unsigned p_blim;
  bit          p_hdr;
  logic [31:0] p_pend;
  bit          p_pend_v;
  bit          p_freq;
  bit          p_te;
  logic [7:0]  p_segs;
  logic [19:0] p_used;
  bit          p_trunc;

  result_t     expected_results[$];
  int          mismatches;
  int          results_seen;
  int          files_done;
  int          items_added;
  int          items_accepted;
  bit          hold_off;

  // Key texts kept locally so the predictor does not borrow from the package.
  function automatic logic [7:0] key_text(int k, int pos);
    string s;
    case (k)
      0: s = "Frequency:";
      1: s = "TE:";
      2: s = "Bit:";
      3: s = "Bit_RAW:";
      default: s = "Data_RAW:";
    endcase
    return (pos < s.len()) ? s[pos] : 8'h00;
  endfunction

  function automatic int key_length(int k);
    case (k)
      0: return 10;
      1: return 3;
      2: return 4;
      3: return 8;
      default: return 9;
    endcase
  endfunction

  task automatic push_result(res_kind_t rk, logic [31:0] v, logic [7:0] d,
                             logic [3:0] c, logic [7:0] sg, logic [1:0] st);
    result_t r;
    r.result_kind = rk;
    r.value = v;
    r.data_bits = d;
    r.bit_count = c;
    r.segment_index = sg;
    r.status = st;
    r.last = 1'b0;
    expected_results.push_back(r);
  endtask

  task automatic clear_line_state();
    p_len = 0; p_ovf = 0; p_ks = KS_START; p_cands = '0; p_kpos = 0;
    p_np = NP_WS; p_sat = 0; p_acc = '0; p_neg = 0; p_hi = '0;
    p_emitted = 0; p_blim = 0; p_hdr = 0;
  endtask

  task automatic clear_file_state();
    clear_line_state();
    p_pend = '0; p_pend_v = 0; p_freq = 0; p_te = 0;
    p_segs = '0; p_used = '0; p_trunc = 0;
  endtask

  task automatic open_segment();
    int unsigned declared;
    int unsigned lim;
    int unsigned remaining;
    declared = p_pend_v ? p_pend : 0;
    p_pend_v = 0;
    p_pend = '0;
    if (p_segs >= lim_segs || p_used >= lim_total) begin
      p_trunc = 1;
      p_ks = KS_IGNORE;
      return;
    end
    remaining = 32'(lim_total) - 32'(p_used);
    lim = 32'(lim_seg_bits);
    if (remaining < lim) lim = remaining;
    p_emitted = 0;
    p_hi = '0;
    if (declared != 0) begin
      p_hdr = 1;
      if (declared > lim) begin
        p_trunc = 1;
        declared = lim;
      end
      p_blim = declared;
      p_ks = (p_blim == 0) ? KS_IGNORE : KS_HEX;
    end else begin
      p_hdr = 0;
      p_blim = lim;
      p_ks = KS_HEX;
    end
  endtask

  task automatic match_key(logic [7:0] c);
    logic [4:0] keep;
    keep = '0;
    for (int k = 0; k < 5; k++) begin
      if (p_cands[k] && p_kpos < key_length(k) && key_text(k, p_kpos) == c) keep[k] = 1'b1;
    end
    p_cands = keep;
    if (keep == '0) begin
      p_ks = KS_IGNORE;
      return;
    end
    for (int k = 0; k < 5; k++) begin
      if (keep[k] && key_length(k) == p_kpos + 1) begin
        p_np = NP_WS; p_acc = '0; p_neg = 0; p_sat = 0;
        case (k)
          0: p_ks = KS_FREQ;
          1: p_ks = KS_TE;
          2: p_ks = KS_BIT;
          3: p_ks = KS_BITRAW;
          default: open_segment();
        endcase
        return;
      end
    end
    p_kpos++;
  endtask

  task automatic number_byte(logic [7:0] c);
    logic [31:0] d;
    if (c >= "0" && c <= "9" && p_np != NP_DONE) begin
      d = 32'(c - "0");
      p_np = NP_DIGITS;
      if (p_sat) return;
      if (p_acc > (32'hFFFF_FFFF - d) / 10) begin
        p_acc = 32'hFFFF_FFFF;
        p_sat = 1;
      end else begin
        p_acc = p_acc * 10 + d;
      end
      return;
    end
    if (p_np == NP_WS) begin
      if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C) return;
      if (c == "+" || c == "-") begin
        p_neg = (c == "-");
        p_np = NP_SIGNED;
        return;
      end
    end
    p_np = NP_DONE;
  endtask

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic hex_byte(logic [7:0] c);
    int          v;
    logic [7:0]  b;
    int unsigned k;
    if (c == 8'h00) begin
      p_ks = KS_HEXSTOP;
      return;
    end
    v = nibble_of(c);
    if (v < 0) return;
    if (!p_hi[4]) begin
      p_hi = {1'b1, v[3:0]};
      return;
    end
    b = {p_hi[3:0], v[3:0]};
    p_hi = '0;
    if (p_emitted >= p_blim) begin
      if (!p_hdr) p_trunc = 1;
      return;
    end
    k = p_blim - p_emitted;
    if (k > 8) k = 8;
    if (k < 8 && !p_hdr) p_trunc = 1;
    b = b & (8'hFF << (8 - k));
    push_result(RK_DATA, '0, b, k[3:0], p_segs, ST_OK);
    p_emitted += k;
  endtask

  task automatic close_line();
    logic [31:0] v;
    int unsigned seg_len;
    if (p_ovf) p_trunc = 1;
    case (p_ks)
      KS_FREQ, KS_TE, KS_BIT, KS_BITRAW: begin
        v = p_acc;
        if (!p_sat && p_neg) v = -v;
        case (p_ks)
          KS_FREQ: begin
            push_result(RK_FREQ, v, '0, '0, '0, ST_OK);
            p_freq = 1;
          end
          KS_TE: begin
            push_result(RK_TE, v, '0, '0, '0, ST_OK);
            p_te = 1;
          end
          KS_BIT: push_result(RK_BIT, v, '0, '0, '0, ST_OK);
          default: begin
            p_pend = v;
            p_pend_v = 1;
          end
        endcase
      end
      KS_HEX, KS_HEXSTOP: begin
        seg_len = p_emitted;
        if (p_hdr) begin
          if (p_emitted < p_blim) begin
            push_result(RK_PAD, p_blim - p_emitted, '0, '0, p_segs, ST_OK);
            p_trunc = 1;
          end
          seg_len = p_blim;
        end
        if (seg_len > 0) begin
          push_result(RK_SEG_END, seg_len, '0, '0, p_segs, ST_OK);
          p_segs = p_segs + 8'd1;
          p_used = p_used + seg_len[19:0];
        end
      end
      default: ;
    endcase
    clear_line_state();
  endtask

  // Advance the parser copy by one accepted transaction; mark the last result.
  task automatic predict_transaction(logic k, logic [7:0] c);
    int         before_n;
    status_t    st;
    before_n = expected_results.size();
    items_accepted++;
    if (k) begin
      close_line();
      if (!p_freq || !p_te) st = ST_MISSING;
      else if (p_segs == 0) st = ST_NODATA;
      else if (p_trunc) st = ST_TRUNC;
      else st = ST_OK;
      push_result(RK_DONE, '0, '0, '0, '0, st);
      clear_file_state();
      files_done++;
    end else if (c == 8'h0A || c == 8'h0D) begin
      close_line();
    end else if (!p_ovf && p_len + 1 < LINE_LIMIT) begin
      p_len++;
      case (p_ks)
        KS_START: begin
          if (!(c == " " || c == 8'h09)) begin
            p_ks = KS_MATCH;
            p_cands = 5'h1F;
            p_kpos = 0;
            match_key(c);
          end
        end
        KS_MATCH: match_key(c);
        KS_FREQ, KS_TE, KS_BIT, KS_BITRAW: begin
          if (c == 8'h00) p_np = NP_DONE;
          else number_byte(c);
        end
        KS_HEX: hex_byte(c);
        default: ;
      endcase
    end else begin
      p_ovf = 1;
    end
    if (expected_results.size() > before_n)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus: a text stream as a queue of bytes with an end-of-file marker.
  typedef struct {
    logic       k;
    logic [7:0] c;
  } tx_t;
  tx_t stream[$];

  task automatic add_text(string s);
    tx_t t;
    for (int i = 0; i < s.len(); i++) begin
      t.k = 0; t.c = s[i];
      stream.push_back(t);
      items_added++;
    end
  endtask

  task automatic add_byte(logic [7:0] b);
    tx_t t;
    t.k = 0; t.c = b;
    stream.push_back(t);
    items_added++;
  endtask

  task automatic add_eof(logic [7:0] junk);
    tx_t t;
    t.k = 1; t.c = junk;
    stream.push_back(t);
    items_added++;
  endtask

  function automatic string rand_hex(int pairs);
    string s;
    string digits;
    s = "";
    digits = "0123456789abcdefABCDEF";
    for (int i = 0; i < 2 * pairs; i++) begin
      s = {s, string'(digits[$urandom_range(21, 0)])};
      if ($urandom_range(9, 0) == 0) s = {s, " "};
    end
    return s;
  endfunction

  function automatic string eol();
    return ($urandom_range(1, 0) != 0) ? "\n" : "\r";
  endfunction

  // One random file: mostly well-formed lines with random content, some noise.
  task automatic add_random_file();
    int nlines;
    nlines = $urandom_range(6, 2);
    for (int i = 0; i < nlines; i++) begin
      if ($urandom_range(1, 0) != 0) add_text(" ");
      case ($urandom_range(9, 0))
        0, 1: add_text($sformatf("Frequency: %0d%s", $urandom, eol()));
        2: add_text($sformatf("TE: %s%0d%s", ($urandom_range(1, 0) != 0) ? "-" : "+",
                              $urandom_range(999, 0), eol()));
        3: add_text($sformatf("Bit: %0d%s", $urandom_range(64, 0), eol()));
        4, 5: add_text($sformatf("Bit_RAW: %0d%s", $urandom_range(24, 0), eol()));
        6, 7: add_text({"Data_RAW: ", rand_hex($urandom_range(4, 0)), eol()});
        8: add_text({"Bitx: 12", eol()});
        default: begin
          for (int j = $urandom_range(4, 1); j > 0; j--) add_byte(8'($urandom_range(255, 0)));
          add_text(eol());
        end
      endcase
    end
    add_eof(8'($urandom_range(255, 0)));
  endtask

  // Input side: walk the stream, with random gaps; valid held while stalled.
  initial begin
    int gap;
    in_valid = 1'b0;
    kind = 1'b0;
    character = 8'h00;
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        predict_transaction(kind, character);
        void'(stream.pop_front());
        gap = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 1) :
              ($urandom_range(1, 0) ? 0 : $urandom_range(2, 1));
        if (gap > 0 || stream.size() == 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        if (stream.size() > 0) begin
          in_valid <= 1'b1;
          kind <= stream[0].k;
          character <= stream[0].c;
        end
      end else if (!in_valid && stream.size() > 0) begin
        in_valid <= 1'b1;
        kind <= stream[0].k;
        character <= stream[0].c;
      end
    end
  end

  // Output side: random stall, or a long hold-off when asked.
  initial begin
    int r;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1'b1;
      else begin
        r = $urandom_range(19, 0);
        if (r == 0) out_stall <= 1'b1;
        else if (r < 5) out_stall <= ($urandom_range(1, 0) != 0);
        else out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off in the middle of a random stretch, counted in its own process.
  initial begin
    hold_off = 1'b0;
    wait (items_accepted >= 200);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t w;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result_kind", {29'd0, result_kind}, 32'd0);
      end else begin
        w = expected_results.pop_front();
        if (result_kind !== w.result_kind) report_mismatch("result_kind", result_kind, w.result_kind);
        if (value !== w.value) report_mismatch("value", value, w.value);
        if (data_bits !== w.data_bits) report_mismatch("data_bits", data_bits, w.data_bits);
        if (bit_count !== w.bit_count) report_mismatch("bit_count", bit_count, w.bit_count);
        if (segment_index !== w.segment_index)
          report_mismatch("segment_index", segment_index, w.segment_index);
        if (status !== w.status) report_mismatch("status", status, w.status);
        if (last !== w.last) report_mismatch("last", last, w.last);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [19:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_SEGMENTS: lim_segs = d[7:0];
      CFG_MAX_SEG_BITS: lim_seg_bits = d[15:0];
      default: lim_total = d;
    endcase
    @(posedge clk);
  endtask

  // Let the stream drain, then settle the pipe before a register write.
  task automatic wait_idle();
    while (stream.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Directed table: one row is a text fragment; kept short.
  string directed_rows[$];

  initial begin
    mismatches = 0;
    results_seen = 0;
    files_done = 0;
    items_added = 0;
    items_accepted = 0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_SEGMENTS;
    cfg_data = '0;
    lim_segs = 8'd16;
    lim_seg_bits = 16'd16384;
    lim_total = 20'd65536;
    clear_file_state();
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, signs, saturation, pad, NUL, hex noise.
    directed_rows = '{
      "Frequency: 4294967295\n",
      "TE: -7\r",
      "Bit: 99999999999\n",
      "\tBit_RAW: 12\n",
      "Data_RAW: FF\n",
      "Data_RAW: 0a zz B\n"
    };
    foreach (directed_rows[i]) add_text(directed_rows[i]);
    add_text("Data_RAW: 8");
    add_byte(8'h00);
    add_text("1\n");
    add_eof(8'hFF);
    add_eof(8'h00);
    wait_idle();

    // Tight limits.
    write_reg(CFG_MAX_SEGMENTS, 20'd1);
    write_reg(CFG_MAX_SEG_BITS, 20'd1);
    write_reg(CFG_MAX_TOTAL_BITS, 20'd1);
    add_text("Frequency:1\nTE:2\nData_RAW: 80\nData_RAW: FF\n");
    add_eof(8'h00);
    wait_idle();

    // Widest limits, random files.
    write_reg(CFG_MAX_SEGMENTS, 20'd255);
    write_reg(CFG_MAX_SEG_BITS, 20'hFFFF);
    write_reg(CFG_MAX_TOTAL_BITS, 20'hFFFFF);
    while (items_added < 230) add_random_file();
    wait_idle();

    // Mid limits, random files.
    write_reg(CFG_MAX_SEGMENTS, 20'd3);
    write_reg(CFG_MAX_SEG_BITS, 20'd13);
    write_reg(CFG_MAX_TOTAL_BITS, 20'd30);
    while (items_added < 310) add_random_file();
    wait_idle();

    repeat (20) @(posedge clk);
    $display("covered %0d files over %0d bytes, %0d results checked", files_done,
             items_accepted, results_seen);
    $display("limits exercised at default, tight, widest and mid settings");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
